>>> rtl/core/sliding_window_median_defines.svh
// ----------------------------------------------------------------------------
// Sliding window median: assertion macros
// Property shorthands for the checks at the end of the top level. They refer to
// clk and arst_n of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define SWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median package
// Sizes, sample and index types, and the control bundle shared by the cells.
// ----------------------------------------------------------------------------
package swm_pkg;

	localparam int MAX_WINDOW   = 64;
	localparam int SAMPLE_WIDTH = 32;
	localparam int CFG_W        = 7;
	localparam int IDX_W        = $clog2(MAX_WINDOW);
	localparam int CNT_W        = $clog2(MAX_WINDOW + 1);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef logic [IDX_W-1:0]               idx_t;
	typedef logic [CNT_W-1:0]               cnt_t;
	typedef logic [CFG_W-1:0]               cfg_t;

	// Broadcast from the sequencer to every cell
	typedef struct packed {
		logic    shift;   // take in a new sample, restart the rank count
		logic    rotate;  // advance the probe ring and compare against bc_val
		sample_t bc_val;  // probe value seen by all cells this cycle
		idx_t    bc_age;  // age of that probe value
		cnt_t    win_k;   // effective window length
		idx_t    tgt;     // rank of the lower median
	} swm_cell_ctrl_t;

	// Clamp the window length register to 1..MAX_WINDOW
	function automatic cnt_t eff_k(cfg_t w);
		if (w == '0) begin
			return CNT_W'(1);
		end else if (int'(w) > MAX_WINDOW) begin
			return CNT_W'(MAX_WINDOW);
		end
		return CNT_W'(w);
	endfunction

endpackage

>>> rtl/core/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window median cell
// Holds one sample of the age-ordered window, a probe value on a ring and the
// rank of its own sample among the window.
// ----------------------------------------------------------------------------
module swm_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  swm_pkg::swm_cell_ctrl_t ctrl,
	input  swm_pkg::idx_t          idx,       // age of the sample held here
	input  swm_pkg::sample_t       shift_in,  // sample from the younger neighbour
	input  swm_pkg::sample_t       probe_in,  // probe from the next cell on the ring
	output swm_pkg::sample_t       val,
	output swm_pkg::sample_t       probe,
	output logic                   hit
);
	import swm_pkg::*;

	sample_t val_q;
	sample_t probe_q;
	idx_t    rank_q;
	logic    less;
	logic    in_win;

	// Ties break on age so that every rank is taken exactly once
	assign less   = (ctrl.bc_val < val_q) ||
	                ((ctrl.bc_val == val_q) && (ctrl.bc_age < idx));
	assign in_win = CNT_W'(idx) < ctrl.win_k;
	assign hit    = in_win && (rank_q == ctrl.tgt);
	assign val    = val_q;
	assign probe  = probe_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q   <= shift_in;
			probe_q <= shift_in;
		end else if (ctrl.rotate) begin
			probe_q <= probe_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q <= '0;
		end else if (ctrl.shift) begin
			rank_q <= '0;
		end else if (ctrl.rotate) begin
			rank_q <= rank_q + IDX_W'(less);
		end
	end

endmodule

>>> rtl/core/sliding_window_median.sv
// A sample that completes a window holds the input (tready low) through its K compare steps on the
// probe ring and the select state, which waits while the output register is full; the median is
// then registered. A sample that gives no result does not hold the input.
// The output register lets the next sample enter while a median waits to be taken.
// Reset: fill count cleared, window length set to 1; sample cells are not cleared.
// ----------------------------------------------------------------------------
// Sliding window median
// Lower median over the last K samples, computed by ranking in a chain of cells.
// ----------------------------------------------------------------------------
`include "sliding_window_median_defines.svh"

module sliding_window_median (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0]   cfg_data,       // window_size
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [swm_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata,  // [31:0] sample
	input  logic [0:0]                  s_axis_tuser,   // [0] restart
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [swm_pkg::SAMPLE_WIDTH-1:0] m_axis_tdata   // [31:0] median
);
	import swm_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;

	logic [1:0]      state_q;
	logic [1:0]      state_nxt;
	idx_t            cnt_q;
	cnt_t            fill_q;
	cnt_t            fill_nxt;
	cnt_t            k_q;
	idx_t            tgt_q;
	cfg_t            win_size_q;
	logic            out_valid_q;
	sample_t         median_q;

	logic            in_acc;
	logic            start_cmp;
	cnt_t            k_cfg;
	logic [CNT_W:0]  half_k;
	idx_t            tgt_cfg;
	logic            last_cmp;
	logic            sel_go;
	sample_t         median_sel;
	swm_cell_ctrl_t  cell_ctrl;

	sample_t                 cell_val   [MAX_WINDOW];
	sample_t                 cell_probe [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]   cell_hit;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = median_q;

	assign k_cfg   = eff_k(win_size_q);
	assign half_k  = ({1'b0, k_cfg} + (CNT_W+1)'(1)) >> 1;
	assign tgt_cfg = IDX_W'(half_k - (CNT_W+1)'(1));

	always_comb begin
		if (s_axis_tuser[0]) begin
			fill_nxt = CNT_W'(1);
		end else if (fill_q == CNT_W'(MAX_WINDOW)) begin
			fill_nxt = fill_q;
		end else begin
			fill_nxt = fill_q + CNT_W'(1);
		end
	end

	assign start_cmp = in_acc && (fill_nxt >= k_cfg);
	assign last_cmp  = (CNT_W'(cnt_q) == (k_q - CNT_W'(1)));
	assign sel_go    = (state_q == ST_SEL) && (!out_valid_q || m_axis_tready);

	always_comb begin
		cell_ctrl.shift  = in_acc;
		cell_ctrl.rotate = (state_q == ST_CMP);
		cell_ctrl.bc_val = cell_probe[0];
		cell_ctrl.bc_age = cnt_q;
		cell_ctrl.win_k  = k_q;
		cell_ctrl.tgt    = tgt_q;
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start_cmp) begin
					state_nxt = ST_CMP;
				end
			end
			ST_CMP: begin
				if (last_cmp) begin
					state_nxt = ST_SEL;
				end
			end
			ST_SEL: begin
				if (sel_go) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			fill_q      <= '0;
			k_q         <= CNT_W'(1);
			tgt_q       <= '0;
			win_size_q  <= CFG_W'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_valid && cfg_ready) begin
				win_size_q <= cfg_data;
			end
			if (in_acc) begin
				fill_q <= fill_nxt;
				k_q    <= k_cfg;
				tgt_q  <= tgt_cfg;
				cnt_q  <= '0;
			end else if (state_q == ST_CMP) begin
				cnt_q <= cnt_q + IDX_W'(1);
			end
			if (sel_go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel_go) begin
			median_q <= median_sel;
		end
	end

	// Exactly one cell in the window holds the target rank
	always_comb begin
		median_sel = '0;
		for (int i = 0; i < MAX_WINDOW; i++) begin
			median_sel = median_sel | (cell_hit[i] ? cell_val[i] : '0);
		end
	end

	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		sample_t shift_src;
		sample_t probe_src;

		if (i == 0) begin : g_head
			assign shift_src = sample_t'(s_axis_tdata);
		end else begin : g_body
			assign shift_src = cell_val[i-1];
		end

		if (i == MAX_WINDOW - 1) begin : g_wrap
			assign probe_src = cell_probe[0];
		end else begin : g_next
			assign probe_src = cell_probe[i+1];
		end

		swm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.idx      (IDX_W'(i)),
			.shift_in (shift_src),
			.probe_in (probe_src),
			.val      (cell_val[i]),
			.probe    (cell_probe[i]),
			.hit      (cell_hit[i])
		);
	end

	`SWM_ASSERT_NEXT(a_enter_cmp, start_cmp, state_q == ST_CMP, "ranking not started")
	`SWM_ASSERT_NOW(a_one_hit, state_q == ST_SEL, $onehot(cell_hit), "median rank not unique")
	`SWM_ASSERT_NOW(a_cnt_in_win, state_q == ST_CMP, CNT_W'(cnt_q) < k_q, "probe age too large")
	`SWM_ASSERT_NEXT(a_out_valid, sel_go, m_axis_tvalid, "median not presented")
	`SWM_ASSERT_NEXT(a_out_data, sel_go, m_axis_tdata == $past(median_sel), "median mismatch")

endmodule
